// ===== sv/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor: shared package
// Field widths, register indexes, reset values and the product-stage bundle.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int COORD_W      = 16;
   localparam int DIR_W        = 16;
   localparam int HALF_WIDTH_W = 14;
   localparam int RADIUS_W     = 10;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int PROD_W       = 2 * COORD_W;
   localparam int SQ_W         = 2 * COORD_W - 1;
   localparam int FRAC_BITS    = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_COS      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_SIN      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROBOT_RADIUS = 8'd3;

   localparam logic signed [DIR_W-1:0]   DIR_COS_RESET      = 16'sd16384;
   localparam logic signed [DIR_W-1:0]   DIR_SIN_RESET      = 16'sd0;
   localparam logic [HALF_WIDTH_W-1:0]   HALF_WIDTH_RESET   = 14'd0;
   localparam logic [RADIUS_W-1:0]       ROBOT_RADIUS_RESET = 10'd300;

   // One point after the multiplier stage.
   typedef struct packed {
      logic                      point_valid;
      logic                      last_point;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [PROD_W-1:0]  x_cos;
      logic signed [PROD_W-1:0]  y_sin;
      logic signed [PROD_W-1:0]  y_cos;
      logic signed [PROD_W-1:0]  x_sin;
      logic [SQ_W-1:0]           x_sq;
      logic [SQ_W-1:0]           y_sq;
   } prod_type;

endpackage

// ===== sv/npc_prod.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor: multiplier stage
// Forms the four rotation products and both squares of one point.
// ----------------------------------------------------------------------------
module npc_prod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic                              in_point_valid,
   input  logic                              in_last_point,
   input  logic signed [npc_pkg::COORD_W-1:0] in_x,
   input  logic signed [npc_pkg::COORD_W-1:0] in_y,
   input  logic signed [npc_pkg::DIR_W-1:0]   dir_cos,
   input  logic signed [npc_pkg::DIR_W-1:0]   dir_sin,
   input  logic                              take,
   output logic                              in_ready,
   output logic                              prod_valid,
   output npc_pkg::prod_type                 prod
);
   import npc_pkg::*;

   logic                     prod_valid_ff;
   logic                     prod_valid_in;
   prod_type                 prod_ff;
   prod_type                 prod_in;
   logic signed [PROD_W-1:0] x_sq_full;
   logic signed [PROD_W-1:0] y_sq_full;

   // The stage may load when it is empty or its point is consumed this cycle.
   assign in_ready = !prod_valid_ff || take;

   always_comb begin
      x_sq_full           = in_x * in_x;
      y_sq_full           = in_y * in_y;
      prod_in.point_valid = in_point_valid;
      prod_in.last_point  = in_last_point;
      prod_in.x           = in_x;
      prod_in.y           = in_y;
      prod_in.x_cos       = in_x * dir_cos;
      prod_in.y_sin       = in_y * dir_sin;
      prod_in.y_cos       = in_y * dir_cos;
      prod_in.x_sin       = in_x * dir_sin;
      prod_in.x_sq        = x_sq_full[SQ_W-1:0];
      prod_in.y_sq        = y_sq_full[SQ_W-1:0];
      prod_valid_in       = in_ready ? in_valid : prod_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

// ===== sv/npc_pick.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor: corridor test and running minimum
// Qualifies each point, keeps the nearest one and registers the scan result.
// ----------------------------------------------------------------------------
module npc_pick (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    prod_valid,
   input  npc_pkg::prod_type                       prod,
   input  logic [npc_pkg::HALF_WIDTH_W-1:0]        half_width,
   input  logic [npc_pkg::RADIUS_W-1:0]            robot_radius,
   output logic                                    take,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [2*npc_pkg::COORD_W-1:0]           rsp_tdata,
   output logic                                    rsp_tuser
);
   import npc_pkg::*;

   localparam int SUM_W   = PROD_W + 1;
   localparam int MARGIN_W = HALF_WIDTH_W + 1;
   localparam int LIMIT_W = MARGIN_W + FRAC_BITS;

   logic                      have_best_ff, have_best_in;
   logic [PROD_W-1:0]         best_dist_ff, best_dist_in;
   logic signed [COORD_W-1:0] best_x_ff, best_x_in;
   logic signed [COORD_W-1:0] best_y_ff, best_y_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff, found_in;
   logic signed [COORD_W-1:0] closest_x_ff, closest_x_in;
   logic signed [COORD_W-1:0] closest_y_ff, closest_y_in;

   logic signed [SUM_W-1:0]   along;
   logic signed [SUM_W-1:0]   lateral;
   logic signed [SUM_W-1:0]   lateral_abs;
   logic [MARGIN_W-1:0]       margin;
   logic [LIMIT_W-1:0]        limit;
   logic [PROD_W-1:0]         dist_sq;
   logic                      ahead;
   logic                      inside_lane;
   logic                      better;
   logic                      out_free;

   always_comb begin
      along       = SUM_W'(prod.x_cos) + SUM_W'(prod.y_sin);
      lateral     = SUM_W'(prod.y_cos) - SUM_W'(prod.x_sin);
      lateral_abs = lateral[SUM_W-1] ? -lateral : lateral;
      margin      = MARGIN_W'(half_width) + MARGIN_W'(robot_radius);
      limit       = {margin, {FRAC_BITS{1'b0}}};
      dist_sq     = PROD_W'(prod.x_sq) + PROD_W'(prod.y_sq);
      ahead       = !along[SUM_W-1] && (along != '0);
      inside_lane = lateral_abs[PROD_W-1:0] < PROD_W'(limit);
      better      = prod.point_valid && ahead && inside_lane
                    && (!have_best_ff || dist_sq < best_dist_ff);

      // A closing point needs the result register; other points never wait.
      out_free = !rsp_valid_ff || rsp_tready;
      take     = prod_valid && (!prod.last_point || out_free);

      have_best_in = have_best_ff;
      best_dist_in = best_dist_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      if (take && better) begin
         have_best_in = 1'b1;
         best_dist_in = dist_sq;
         best_x_in    = prod.x;
         best_y_in    = prod.y;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      closest_x_in = closest_x_ff;
      closest_y_in = closest_y_ff;
      if (take && prod.last_point) begin
         rsp_valid_in = 1'b1;
         found_in     = have_best_in;
         closest_x_in = have_best_in ? best_x_in : '0;
         closest_y_in = have_best_in ? best_y_in : '0;
         have_best_in = 1'b0;
         best_dist_in = '0;
         best_x_in    = '0;
         best_y_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         best_dist_ff <= '0;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_best_ff <= have_best_in;
         best_dist_ff <= best_dist_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff     <= found_in;
      closest_x_ff <= closest_x_in;
      closest_y_ff <= closest_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {closest_y_ff, closest_x_ff};
   assign rsp_tuser  = found_ff;

endmodule

// ===== sv/nearest_point_in_corridor.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor
// Path: a closing word passes the input register, the multiplier register
// and the result register before its result word is on rsp_tvalid.
// Throughput: one input word per cycle, except while a closing word waits on
// an untaken result, which backs up the words behind it to the input.
// Reset (synchronous, active high) empties the pipeline, clears the running
// minimum and restores the corridor registers to their defaults.
// ----------------------------------------------------------------------------
module nearest_point_in_corridor (
   input  logic                                 clock,
   input  logic                                 reset,
   // Point stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*npc_pkg::COORD_W-1:0]        req_tdata,  // opp_x, opp_y
   input  logic                                 req_tuser,  // point_valid
   input  logic                                 req_tlast,  // last_point
   // Scan result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*npc_pkg::COORD_W-1:0]        rsp_tdata,  // closest_x, closest_y
   output logic                                 rsp_tuser,  // found
   // Register write port.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [npc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import npc_pkg::*;

   // Corridor registers. The user must write them only while the block is idle;
   // the block does not enforce it. It always accepts them, no pipeline interlock.
   logic signed [DIR_W-1:0]   dir_cos_ff, dir_cos_in;
   logic signed [DIR_W-1:0]   dir_sin_ff, dir_sin_in;
   logic [HALF_WIDTH_W-1:0]   half_width_ff, half_width_in;
   logic [RADIUS_W-1:0]       robot_radius_ff, robot_radius_in;

   // Input register holding one accepted word.
   logic                      in_valid_ff, in_valid_in;
   logic                      in_point_valid_ff;
   logic                      in_last_point_ff;
   logic signed [COORD_W-1:0] in_x_ff;
   logic signed [COORD_W-1:0] in_y_ff;

   logic                      prod_ready;
   logic                      prod_valid;
   prod_type                  prod;
   logic                      take;

   assign csr_ready = 1'b1;

   always_comb begin
      dir_cos_in      = dir_cos_ff;
      dir_sin_in      = dir_sin_ff;
      half_width_in   = half_width_ff;
      robot_radius_in = robot_radius_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIR_COS:      dir_cos_in      = csr_data;
            CSR_DIR_SIN:      dir_sin_in      = csr_data;
            CSR_HALF_WIDTH:   half_width_in   = csr_data[HALF_WIDTH_W-1:0];
            CSR_ROBOT_RADIUS: robot_radius_in = csr_data[RADIUS_W-1:0];
            default: begin
               // Indexes past the register list are dropped.
            end
         endcase
      end
   end

   // The input register frees up whenever its word moves into the multiplier
   // stage, so the stream flows at one word per cycle unless that stage stalls.
   assign req_tready  = !in_valid_ff || prod_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_cos_ff      <= DIR_COS_RESET;
         dir_sin_ff      <= DIR_SIN_RESET;
         half_width_ff   <= HALF_WIDTH_RESET;
         robot_radius_ff <= ROBOT_RADIUS_RESET;
         in_valid_ff     <= 1'b0;
      end else begin
         dir_cos_ff      <= dir_cos_in;
         dir_sin_ff      <= dir_sin_in;
         half_width_ff   <= half_width_in;
         robot_radius_ff <= robot_radius_in;
         in_valid_ff     <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_point_valid_ff <= req_tuser;
         in_last_point_ff  <= req_tlast;
         in_x_ff           <= req_tdata[COORD_W-1:0];
         in_y_ff           <= req_tdata[2*COORD_W-1:COORD_W];
      end
   end

   // Rotation products and squared coordinates, one point per cycle unless stalled.
   npc_prod u_prod (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (in_valid_ff),
      .in_point_valid (in_point_valid_ff),
      .in_last_point  (in_last_point_ff),
      .in_x           (in_x_ff),
      .in_y           (in_y_ff),
      .dir_cos        (dir_cos_ff),
      .dir_sin        (dir_sin_ff),
      .take           (take),
      .in_ready       (prod_ready),
      .prod_valid     (prod_valid),
      .prod           (prod)
   );

   // Corridor test, running minimum and the result register.
   npc_pick u_pick (
      .clock        (clock),
      .reset        (reset),
      .prod_valid   (prod_valid),
      .prod         (prod),
      .half_width   (half_width_ff),
      .robot_radius (robot_radius_ff),
      .take         (take),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ===== tb/npc_scan_checker.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor: scan result checker
// Watches the point, result and register channels, keeps its own copy of the
// corridor settings and of the running nearest point, and compares each
// result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module npc_scan_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [2*npc_pkg::COORD_W-1:0]        req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [2*npc_pkg::COORD_W-1:0]        rsp_tdata,
   input  logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [npc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [npc_pkg::CSR_DATA_W-1:0]       csr_data,
   output int                                   error_count,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import npc_pkg::*;

   typedef struct packed {
      logic                      found;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } scan_result_type;

   logic signed [DIR_W-1:0]    cos_q;
   logic signed [DIR_W-1:0]    sin_q;
   logic [HALF_WIDTH_W-1:0]    half_width;
   logic [RADIUS_W-1:0]        radius;

   logic                       have_best;
   logic [31:0]                best_dist_sq;
   logic signed [COORD_W-1:0]  best_x;
   logic signed [COORD_W-1:0]  best_y;

   scan_result_type            scan_results_q[$];

   // A point qualifies when it lies strictly ahead and strictly inside the
   // corridor. All products are exact, so 64 bits hold them with room to spare.
   function automatic bit in_corridor(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y);
      longint along;
      longint lateral;
      longint limit;
      along   = longint'(x) * cos_q + longint'(y) * sin_q;
      lateral = longint'(y) * cos_q - longint'(x) * sin_q;
      if (lateral < 0)
         lateral = -lateral;
      limit = (longint'(half_width) + longint'(radius)) <<< FRAC_BITS;
      return (along > 0) && (lateral < limit);
   endfunction

   always @(posedge clock) begin
      scan_result_type            seen;
      scan_result_type            want;
      logic signed [COORD_W-1:0]  px;
      logic signed [COORD_W-1:0]  py;
      logic [31:0]                dist_sq;
      if (reset) begin
         cos_q        = DIR_COS_RESET;
         sin_q        = DIR_SIN_RESET;
         half_width   = HALF_WIDTH_RESET;
         radius       = ROBOT_RADIUS_RESET;
         have_best    = 1'b0;
         best_dist_sq = '0;
         best_x       = '0;
         best_y       = '0;
         scan_results_q.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.found = rsp_tuser;
            seen.x     = rsp_tdata[COORD_W-1:0];
            seen.y     = rsp_tdata[2*COORD_W-1:COORD_W];
            if (scan_results_q.size() == 0) begin
               $error("result word with no scan closed: found %0d x %0d y %0d",
                      seen.found, seen.x, seen.y);
               error_count++;
            end else begin
               want = scan_results_q.pop_front();
               if (seen.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, seen.found);
                  error_count++;
               end
               if (seen.x !== want.x) begin
                  $error("closest_x: expected %0d, got %0d", want.x, seen.x);
                  error_count++;
               end
               if (seen.y !== want.y) begin
                  $error("closest_y: expected %0d, got %0d", want.y, seen.y);
                  error_count++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIR_COS:      cos_q      = csr_data;
               CSR_DIR_SIN:      sin_q      = csr_data;
               CSR_HALF_WIDTH:   half_width = csr_data[HALF_WIDTH_W-1:0];
               CSR_ROBOT_RADIUS: radius     = csr_data[RADIUS_W-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            px      = req_tdata[COORD_W-1:0];
            py      = req_tdata[2*COORD_W-1:COORD_W];
            dist_sq = 32'(longint'(px) * px + longint'(py) * py);
            if (req_tuser && in_corridor(px, py) &&
                (!have_best || dist_sq < best_dist_sq)) begin
               have_best    = 1'b1;
               best_dist_sq = dist_sq;
               best_x       = px;
               best_y       = py;
            end
            if (req_tlast) begin
               want.found = have_best;
               want.x     = have_best ? best_x : '0;
               want.y     = have_best ? best_y : '0;
               scan_results_q.push_back(want);
               have_best    = 1'b0;
               best_dist_sq = '0;
               best_x       = '0;
               best_y       = '0;
            end
         end
         pending <= scan_results_q.size();
      end
   end

endmodule

// ===== tb/nearest_point_in_corridor_tb.sv =====
// ----------------------------------------------------------------------------
// Nearest point in corridor: testbench top
// Drives scans of points through several corridor settings and idling
// patterns; a checker beside the block predicts each scan result and counts
// mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module nearest_point_in_corridor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no accepted word before the run is declared hung. The longest
   // correct quiet stretch is the deliberate receiver hold-off below.
   localparam int WATCHDOG_LIMIT = 2000;
   // Lets in-flight points land before the corridor registers change.
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 300;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                                   clock      = 1'b0;
   logic                                   reset      = 1'b1;
   logic                                   req_tvalid = 1'b0;
   logic                                   req_tready;
   logic [2*npc_pkg::COORD_W-1:0]          req_tdata  = '0;  // opp_x, opp_y
   logic                                   req_tuser  = 1'b0; // point_valid
   logic                                   req_tlast  = 1'b0; // last_point
   logic                                   rsp_tvalid;
   logic                                   rsp_tready = 1'b0;
   logic [2*npc_pkg::COORD_W-1:0]          rsp_tdata;  // closest_x, closest_y
   logic                                   rsp_tuser;  // found
   logic                                   csr_valid  = 1'b0;
   logic                                   csr_ready;
   logic [npc_pkg::CSR_INDEX_W-1:0]        csr_index  = '0;
   logic [npc_pkg::CSR_DATA_W-1:0]         csr_data   = '0;

   int error_count;
   int pending;

   // Idling percentages, read by the sender task and the receiver process.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Each bump of hold_req asks the receiver for one long hold-off.
   int hold_req  = 0;
   int hold_ack  = 0;
   int hold_left = 0;

   int quiet_cycles = 0;

   // Copy of the current corridor, used only to aim random points at it.
   int gen_cos  = 16384;
   int gen_sin  = 0;
   int gen_span = 300;

   logic signed [npc_pkg::COORD_W-1:0] prev_x = '0;
   logic signed [npc_pkg::COORD_W-1:0] prev_y = '0;
   logic signed [npc_pkg::COORD_W-1:0] corners[5] = '{-32768, -1, 0, 1, 32767};

   always #5 clock = ~clock;

   nearest_point_in_corridor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   npc_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .pending     (pending)
   );

   // Receiver. It stalls at random by stall_pct, except during a requested
   // hold-off, when it refuses every result word so that the result register
   // fills and the block has to push back on closing words.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_ack != hold_req) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: any accepted word on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("nearest_point_in_corridor_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [15:0] saturate16(input longint v);
      if (v > 32767)
         return 16'sd32767;
      if (v < -32768)
         return -16'sd32768;
      return v[15:0];
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
         default:       begin send_idle_pct = 10; stall_pct = 10; end
      endcase
   endtask

   // Offers one point word and returns at the edge where it was taken.
   // tvalid stays high into the next word unless a gap is drawn, so it is
   // never lowered and raised within one time step.
   task automatic send_word(input logic pv,
                            input logic signed [15:0] x,
                            input logic signed [15:0] y,
                            input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= pv;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Register write without lowering csr_valid, so back-to-back writes keep
   // it high; the caller drops it after the last one.
   task automatic write_reg(input logic [npc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [npc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Programs all four corridor registers. Unused upper data bits of the
   // narrow registers carry random junk, and one write goes to an index past
   // the register map, which the block must ignore.
   task automatic set_corridor(input logic signed [15:0] cos_v,
                               input logic signed [15:0] sin_v,
                               input logic [13:0] half_width,
                               input logic [9:0] radius);
      write_reg(npc_pkg::CSR_DIR_COS, cos_v);
      write_reg(npc_pkg::CSR_DIR_SIN, sin_v);
      write_reg(npc_pkg::CSR_HALF_WIDTH, {2'($urandom), half_width});
      write_reg(npc_pkg::CSR_ROBOT_RADIUS, {6'($urandom), radius});
      write_reg(npc_pkg::CSR_INDEX_W'(int'(npc_pkg::CSR_ROBOT_RADIUS) + 1 +
                                      int'($urandom_range(0, 251))),
                16'($urandom));
      csr_valid <= 1'b0;
      gen_cos  = cos_v;
      gen_sin  = sin_v;
      gen_span = half_width + radius;
   endtask

   // Waits until every predicted result has been taken, then lets the
   // pipeline empty of points from scans that are still open.
   task automatic settle();
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Most points are aimed near the corridor, straddling both side edges and
   // the zero line of the along-axis. The rest are anywhere, full-scale
   // corners, or a reflection of the previous point, which has the same
   // squared length and so exercises the first-wins tie rule.
   task automatic random_point(output logic signed [15:0] x,
                               output logic signed [15:0] y);
      int     pick;
      int     along;
      int     lat;
      longint rx;
      longint ry;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         along = $urandom_range(0, 6000) - 300;
         lat   = $urandom_range(0, 2 * gen_span + 100) - (gen_span + 50);
         rx = (longint'(along) * gen_cos - longint'(lat) * gen_sin) >>> 14;
         ry = (longint'(along) * gen_sin + longint'(lat) * gen_cos) >>> 14;
         x  = saturate16(rx);
         y  = saturate16(ry);
      end else if (pick < 75) begin
         x = 16'($urandom);
         y = 16'($urandom);
      end else if (pick < 88) begin
         x = corners[$urandom_range(0, 4)];
         y = corners[$urandom_range(0, 4)];
      end else begin
         case ($urandom_range(0, 3))
            0:       begin x = prev_x;  y = -prev_y; end
            1:       begin x = -prev_x; y = prev_y;  end
            2:       begin x = prev_y;  y = prev_x;  end
            default: begin x = -prev_y; y = -prev_x; end
         endcase
      end
      prev_x = x;
      prev_y = y;
   endtask

   // Random scans, mostly short, now and then long. About one word in ten is
   // a dropped point carrying junk coordinates; a scan may close on one.
   // Stops after the scan in which the count is reached, so every phase ends
   // with its scan closed.
   task automatic run_scans(input int count);
      int                 sent;
      int                 len;
      logic               pv;
      logic signed [15:0] x;
      logic signed [15:0] y;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            pv = ($urandom_range(0, 9) != 0);
            random_point(x, y);
            send_word(pv, x, y, k == len - 1);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed scans at the reset corridor: straight ahead, no half width,
      // so a point counts when x > 0 and |y| < 300.
      // Empty scan closed by a dropped word.
      send_word(1'b0, 16'sd0, 16'sd0, 1'b1);
      // Nearer point arriving second wins.
      send_word(1'b1, 16'sd100, 16'sd0, 1'b0);
      send_word(1'b1, 16'sd50, 16'sd10, 1'b1);
      // Equal squared length: the first one stays. Points level with the robot
      // and behind it do not count.
      send_word(1'b1, 16'sd30, 16'sd40, 1'b0);
      send_word(1'b1, 16'sd40, 16'sd30, 1'b0);
      send_word(1'b1, 16'sd0, 16'sd50, 1'b0);
      send_word(1'b1, -16'sd50, 16'sd0, 1'b0);
      send_word(1'b0, 16'sd0, 16'sd0, 1'b1);
      // Lateral edge is exclusive on both sides.
      send_word(1'b1, 16'sd1000, 16'sd300, 1'b0);
      send_word(1'b1, 16'sd1000, -16'sd300, 1'b0);
      send_word(1'b1, 16'sd2000, 16'sd299, 1'b1);
      send_word(1'b1, 16'sd1000, -16'sd299, 1'b1);
      // Full-scale coordinates.
      send_word(1'b1, -16'sd32768, -16'sd32768, 1'b0);
      send_word(1'b1, 16'sd32767, 16'sd299, 1'b0);
      send_word(1'b1, 16'sd32767, -16'sd1, 1'b1);
      // A dropped point must not take part even when it is the nearest.
      send_word(1'b0, 16'sd5, 16'sd5, 1'b0);
      send_word(1'b1, 16'sd200, 16'sd0, 1'b1);
      // Origin is not ahead; a dropped word with junk closes an empty scan.
      send_word(1'b1, 16'sd0, 16'sd0, 1'b1);
      send_word(1'b0, -16'sd32768, 16'sd32767, 1'b1);
      req_tvalid <= 1'b0;
      settle();

      // Ordinary forward corridor, no idling.
      set_idling(IDLE_NONE);
      set_corridor(16'sd16384, 16'sd0, 14'd500, 10'd300);
      run_scans(200);
      settle();

      // Corridor to the left at the widest setting, sender idling.
      set_idling(IDLE_SENDER);
      set_corridor(16'sd0, 16'sd16384, 14'd16383, 10'd1023);
      run_scans(200);
      settle();

      // Backward with zero width: nothing can ever qualify. Receiver stalls.
      set_idling(IDLE_RECEIVER);
      set_corridor(-16'sd16384, 16'sd0, 14'd0, 10'd0);
      run_scans(100);
      settle();

      // Direction far from a unit vector, taken as is. Both sides idle.
      set_idling(IDLE_BOTH);
      set_corridor(-16'sd32768, -16'sd32768, 14'd1000, 10'd0);
      run_scans(200);
      settle();

      // Diagonal corridor under back-pressure: the receiver holds off while
      // scans keep coming, then the sender waits for every result before
      // carrying on.
      set_idling(IDLE_NONE);
      set_corridor(16'sd11585, 16'sd11585, 14'd200, 10'd300);
      hold_req = hold_req + 1;
      run_scans(75);
      settle();
      run_scans(75);
      settle();

      // Random corridors under each idling pattern.
      for (int round = 0; round < 4; round++) begin
         set_idling(idle_mode_type'(round));
         set_corridor(16'($urandom), 16'($urandom), 14'($urandom), 10'($urandom));
         run_scans(100);
         settle();
      end

      if (error_count == 0 && pending == 0) begin
         $display("nearest_point_in_corridor_tb OK");
      end else begin
         $display("nearest_point_in_corridor_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/npc_pkg.sv
sv/npc_prod.sv
sv/npc_pick.sv
sv/nearest_point_in_corridor.sv
tb/npc_scan_checker.sv
tb/nearest_point_in_corridor_tb.sv
